[design/tracker_cell_delta_encoder_defines.svh]
// Assertion macros used by the tracker cell delta encoder design file.
`ifndef TRACKER_CELL_DELTA_ENCODER_DEFINES_SVH
`define TRACKER_CELL_DELTA_ENCODER_DEFINES_SVH

// Checks a property at every rising clock edge outside of reset.
`define TCDE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define TCDE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/tcde_pkg.sv]
// Package with the constants, types and decode functions of the tracker cell delta encoder.
package tcde_pkg;

   // Number of channels with stored state, and the width of a channel index.
   localparam int unsigned CHANNELS = 8;
   localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Character codes used by the cell decode.
   localparam logic [7:0] CaseMask   = 8'hDF;
   localparam logic [7:0] NoNoteCode = 8'h0D;
   localparam logic [7:0] RestCode   = 8'h52;
   localparam logic [7:0] LetterA    = 8'h41;
   localparam logic [7:0] LetterF    = 8'h46;
   localparam logic [7:0] LetterG    = 8'h47;
   localparam logic [7:0] SharpCode  = 8'h23;
   localparam logic [7:0] DashCode   = 8'h2D;
   localparam logic [7:0] Digit0     = 8'h30;
   localparam logic [7:0] Digit1     = 8'h31;
   localparam logic [7:0] Digit9     = 8'h39;
   localparam logic [7:0] MaxOctave  = 8'd5;
   localparam logic [6:0] NoteCount  = 7'd72;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_WAVE_OP   = 2'd0,
      CSR_VOLUME_OP = 2'd1,
      CSR_FREQ_OP   = 2'd2
   } csr_index_type;

   // Decoded hex digit field.
   typedef struct packed {
      logic       bad;
      logic       has;
      logic [3:0] val;
   } hex_type;

   // Decoded note field.
   typedef struct packed {
      logic        bad;
      logic        has;
      logic [10:0] freq;
   } note_type;

   // Semitone offset of each letter, starting at A.
   function automatic logic [3:0] letter_step(input logic [2:0] idx);
      logic [3:0] step;
      case (idx)
         3'd0:    step = 4'd9;
         3'd1:    step = 4'd11;
         3'd2:    step = 4'd0;
         3'd3:    step = 4'd2;
         3'd4:    step = 4'd4;
         3'd5:    step = 4'd5;
         3'd6:    step = 4'd7;
         default: step = 4'd0;
      endcase
      return step;
   endfunction

   // Frequency of each semitone over six octaves.
   function automatic logic [10:0] freq_lookup(input logic [6:0] step);
      logic [10:0] f;
      case (step)
         7'd0:  f = 11'd33;   7'd1:  f = 11'd35;   7'd2:  f = 11'd37;   7'd3:  f = 11'd39;
         7'd4:  f = 11'd41;   7'd5:  f = 11'd44;   7'd6:  f = 11'd46;   7'd7:  f = 11'd49;
         7'd8:  f = 11'd52;   7'd9:  f = 11'd55;   7'd10: f = 11'd58;   7'd11: f = 11'd62;
         7'd12: f = 11'd65;   7'd13: f = 11'd69;   7'd14: f = 11'd73;   7'd15: f = 11'd78;
         7'd16: f = 11'd82;   7'd17: f = 11'd87;   7'd18: f = 11'd92;   7'd19: f = 11'd98;
         7'd20: f = 11'd104;  7'd21: f = 11'd110;  7'd22: f = 11'd117;  7'd23: f = 11'd123;
         7'd24: f = 11'd131;  7'd25: f = 11'd139;  7'd26: f = 11'd147;  7'd27: f = 11'd156;
         7'd28: f = 11'd165;  7'd29: f = 11'd175;  7'd30: f = 11'd185;  7'd31: f = 11'd196;
         7'd32: f = 11'd208;  7'd33: f = 11'd220;  7'd34: f = 11'd233;  7'd35: f = 11'd247;
         7'd36: f = 11'd262;  7'd37: f = 11'd277;  7'd38: f = 11'd294;  7'd39: f = 11'd311;
         7'd40: f = 11'd330;  7'd41: f = 11'd349;  7'd42: f = 11'd370;  7'd43: f = 11'd392;
         7'd44: f = 11'd415;  7'd45: f = 11'd440;  7'd46: f = 11'd466;  7'd47: f = 11'd493;
         7'd48: f = 11'd523;  7'd49: f = 11'd554;  7'd50: f = 11'd587;  7'd51: f = 11'd622;
         7'd52: f = 11'd659;  7'd53: f = 11'd698;  7'd54: f = 11'd740;  7'd55: f = 11'd784;
         7'd56: f = 11'd830;  7'd57: f = 11'd880;  7'd58: f = 11'd932;  7'd59: f = 11'd987;
         7'd60: f = 11'd1047; 7'd61: f = 11'd1109; 7'd62: f = 11'd1175; 7'd63: f = 11'd1245;
         7'd64: f = 11'd1319; 7'd65: f = 11'd1397; 7'd66: f = 11'd1480; 7'd67: f = 11'd1568;
         7'd68: f = 11'd1661; 7'd69: f = 11'd1760; 7'd70: f = 11'd1865; 7'd71: f = 11'd1976;
         default: f = 11'd0;
      endcase
      return f;
   endfunction

   // Decodes a hex digit character, where a dash means no value.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type    r;
      logic [7:0] u;
      logic [7:0] d;
      u = c & CaseMask;
      r = '0;
      if (c == DashCode) begin
         r.has = 1'b0;
      end else if (c >= Digit0 && c <= Digit9) begin
         d = c - Digit0;
         r.has = 1'b1;
         r.val = d[3:0];
      end else if (u >= LetterA && u <= LetterF) begin
         d = u - LetterA + 8'd10;
         r.has = 1'b1;
         r.val = d[3:0];
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   // Decodes the note letter, sharp mark and octave digit into a frequency.
   function automatic note_type note_decode(input logic [7:0] nc, input logic [7:0] sc,
                                            input logic [7:0] oc);
      note_type   r;
      logic [7:0] letter;
      logic [7:0] octave;
      logic [7:0] lidx;
      logic [6:0] step;
      letter = nc & CaseMask;
      octave = oc - Digit1;
      lidx   = letter - LetterA;
      r      = '0;
      step   = {3'b000, letter_step(lidx[2:0])} + {6'd0, (sc == SharpCode)};
      step   = step + {2'b00, octave[2:0], 2'b00} + {1'b0, octave[2:0], 3'b000};
      if (letter == NoNoteCode) begin
         r.has = 1'b0;
      end else if (letter == RestCode) begin
         r.has = 1'b1;
      end else if (letter < LetterA || letter > LetterG) begin
         r.bad = 1'b1;
      end else if (octave > MaxOctave) begin
         r.bad = 1'b1;
      end else if (step >= NoteCount) begin
         // B sharp in the top octave falls past the end of the table.
         r.bad = 1'b1;
      end else begin
         r.has  = 1'b1;
         r.freq = freq_lookup(step);
      end
      return r;
   endfunction

endpackage

[design/tracker_cell_delta_encoder.sv]
// Tracker cell delta encoder: turns tracker cells into byte commands for what changed.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_valid/req_stall  channel, note, sharp, octave, wave, volume chars
//   rsp_*     out        rsp_valid/rsp_stall  out_byte, last, error
//   csr_*     in         csr_valid/csr_ready  index, write data
//
// A cell is registered, decoded and compared against the channel state in the next cycle,
// and its commands, 1 to 10 bytes, are sent from a record register one byte per cycle while
// rsp_stall is low, a rate set by the single byte-wide result port.
// The first byte is offered once the cell has moved from the input into the record register.
// A cell that changes nothing gives no transaction; a bad cell gives one error byte.
// Reset makes every channel's waveform, volume and frequency unknown and restores opcodes.
// A stall on the result side holds the record, then the input register, then req_stall.
`include "tracker_cell_delta_encoder_defines.svh"

module tracker_cell_delta_encoder (
   input  logic       clock,
   input  logic       reset,
   // Cell input channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_channel,
   input  logic [7:0] req_note_char,
   input  logic [7:0] req_sharp_char,
   input  logic [7:0] req_octave_char,
   input  logic [7:0] req_wave_char,
   input  logic [7:0] req_volume_char,
   // Command byte output channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_error,
   // Configuration write channel.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int unsigned ChIdxW = tcde_pkg::ChIdxW;

   // Segment bits of the record: one per pending command.
   localparam int unsigned SegWave = 0;
   localparam int unsigned SegVol  = 1;
   localparam int unsigned SegFreq = 2;

   // Configuration registers.
   logic [7:0] wave_op_ff;
   logic [7:0] vol_op_ff;
   logic [7:0] freq_op_ff;

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] s1_ch_ff;
   logic [7:0] s1_note_ff, s1_sharp_ff, s1_oct_ff, s1_wave_ff, s1_vol_ff;

   // Per-channel state.
   logic        wave_known_ff [tcde_pkg::CHANNELS];
   logic        vol_known_ff  [tcde_pkg::CHANNELS];
   logic        freq_known_ff [tcde_pkg::CHANNELS];
   logic [3:0]  last_wave_ff  [tcde_pkg::CHANNELS];
   logic [3:0]  last_vol_ff   [tcde_pkg::CHANNELS];
   logic [10:0] last_freq_ff  [tcde_pkg::CHANNELS];

   // Record register holding the commands of one cell.
   logic        rec_valid_ff, rec_valid_in;
   logic        rec_err_ff, rec_err_in;
   logic [2:0]  rec_pend_ff, rec_pend_in;
   logic [1:0]  rec_idx_ff, rec_idx_in;
   logic [2:0]  rec_ch_ff;
   logic [3:0]  rec_wave_ff;
   logic [7:0]  rec_volb_ff;
   logic [10:0] rec_freq_ff;

   // Decode signals.
   tcde_pkg::note_type  dec_note;
   tcde_pkg::hex_type   dec_wave;
   tcde_pkg::hex_type   dec_vol;
   logic [ChIdxW-1:0]   dec_idx;
   logic                dec_bad;
   logic                dec_wave_emit;
   logic                dec_vol_has;
   logic [3:0]          dec_vol_val;
   logic                dec_vol_known;
   logic                dec_vol_emit;
   logic                dec_freq_emit;
   logic [7:0]          dec_vol_byte;
   logic                dec_commit;

   // Output sequencing signals.
   logic       rsp_take;
   logic       rec_free;
   logic       s1_move;
   logic [2:0] cur_seg;
   logic [2:0] pend_rest;
   logic       seg_end;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_op_ff <= 8'd0;
         vol_op_ff  <= 8'd1;
         freq_op_ff <= 8'd2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tcde_pkg::CSR_WAVE_OP:   wave_op_ff <= csr_wdata;
            tcde_pkg::CSR_VOLUME_OP: vol_op_ff  <= csr_wdata;
            tcde_pkg::CSR_FREQ_OP:   freq_op_ff <= csr_wdata;
            default:                 wave_op_ff <= wave_op_ff;
         endcase
      end
   end

   // Handshake between the input register and the record register.
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rec_free  = !rec_valid_ff || (rsp_take && rsp_last);
   assign s1_move   = s1_valid_ff && rec_free;
   assign req_stall = s1_valid_ff && !rec_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ch_ff    <= req_channel;
         s1_note_ff  <= req_note_char;
         s1_sharp_ff <= req_sharp_char;
         s1_oct_ff   <= req_octave_char;
         s1_wave_ff  <= req_wave_char;
         s1_vol_ff   <= req_volume_char;
      end
   end

   // Cell decode and comparison against the channel state.
   always_comb begin
      dec_note = tcde_pkg::note_decode(s1_note_ff, s1_sharp_ff, s1_oct_ff);
      dec_wave = tcde_pkg::hex_decode(s1_wave_ff);
      dec_vol  = tcde_pkg::hex_decode(s1_vol_ff);
      dec_idx  = s1_ch_ff[ChIdxW-1:0];
      dec_bad  = dec_note.bad || dec_wave.bad || dec_vol.bad ||
                 (32'(s1_ch_ff) >= tcde_pkg::CHANNELS);

      dec_wave_emit = dec_wave.has &&
                      (!wave_known_ff[dec_idx] || last_wave_ff[dec_idx] != dec_wave.val);

      // A new waveform resends the old volume when the cell gives none.
      dec_vol_has   = dec_vol.has || (dec_wave_emit && vol_known_ff[dec_idx]);
      dec_vol_val   = dec_vol.has ? dec_vol.val : last_vol_ff[dec_idx];
      dec_vol_known = vol_known_ff[dec_idx] && !dec_wave_emit;
      dec_vol_emit  = dec_vol_has &&
                      (!dec_vol_known || last_vol_ff[dec_idx] != dec_vol_val);

      dec_freq_emit = dec_note.has &&
                      (!freq_known_ff[dec_idx] || last_freq_ff[dec_idx] != dec_note.freq);

      // Volume times seven.
      dec_vol_byte = {1'b0, dec_vol_val, 3'b000} - {4'b0000, dec_vol_val};
      dec_commit   = s1_move && !dec_bad;
   end

   // Channel state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tcde_pkg::CHANNELS; i++) begin
            wave_known_ff[i] <= 1'b0;
            vol_known_ff[i]  <= 1'b0;
            freq_known_ff[i] <= 1'b0;
         end
      end else if (dec_commit) begin
         if (dec_wave_emit) begin
            wave_known_ff[dec_idx] <= 1'b1;
         end
         vol_known_ff[dec_idx] <= dec_vol_known || dec_vol_emit;
         if (dec_freq_emit) begin
            freq_known_ff[dec_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dec_commit) begin
         if (dec_wave_emit) begin
            last_wave_ff[dec_idx] <= dec_wave.val;
         end
         if (dec_vol_emit) begin
            last_vol_ff[dec_idx] <= dec_vol_val;
         end
         if (dec_freq_emit) begin
            last_freq_ff[dec_idx] <= dec_note.freq;
         end
      end
   end

   // Current segment is the lowest pending command.
   always_comb begin
      cur_seg   = rec_pend_ff & (~rec_pend_ff + 3'd1);
      pend_rest = rec_pend_ff & ~cur_seg;
      seg_end   = cur_seg[SegFreq] ? (rec_idx_ff == 2'd3) : (rec_idx_ff == 2'd2);
   end

   // Record register next state: load from decode or step through the bytes.
   always_comb begin
      rec_valid_in = rec_valid_ff;
      rec_err_in   = rec_err_ff;
      rec_pend_in  = rec_pend_ff;
      rec_idx_in   = rec_idx_ff;
      if (s1_move) begin
         rec_valid_in = dec_bad || dec_wave_emit || dec_vol_emit || dec_freq_emit;
         rec_err_in   = dec_bad;
         rec_pend_in  = dec_bad ? 3'b000 : {dec_freq_emit, dec_vol_emit, dec_wave_emit};
         rec_idx_in   = 2'd0;
      end else if (rsp_take) begin
         if (rsp_last) begin
            rec_valid_in = 1'b0;
         end else if (seg_end) begin
            rec_pend_in = pend_rest;
            rec_idx_in  = 2'd0;
         end else begin
            rec_idx_in = rec_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         rec_err_ff   <= 1'b0;
         rec_pend_ff  <= 3'b000;
         rec_idx_ff   <= 2'd0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         rec_err_ff   <= rec_err_in;
         rec_pend_ff  <= rec_pend_in;
         rec_idx_ff   <= rec_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rec_ch_ff   <= s1_ch_ff;
         rec_wave_ff <= dec_wave.val;
         rec_volb_ff <= dec_vol_byte;
         rec_freq_ff <= dec_note.freq;
      end
   end

   // Output byte selection.
   always_comb begin
      rsp_valid    = rec_valid_ff;
      rsp_error    = rec_err_ff;
      rsp_last     = rec_err_ff || (seg_end && pend_rest == 3'b000);
      rsp_out_byte = 8'd0;
      if (!rec_err_ff) begin
         case (rec_idx_ff)
            2'd0: rsp_out_byte = {5'd0, rec_ch_ff};
            2'd1: begin
               if (cur_seg[SegWave]) begin
                  rsp_out_byte = wave_op_ff;
               end else if (cur_seg[SegVol]) begin
                  rsp_out_byte = vol_op_ff;
               end else begin
                  rsp_out_byte = freq_op_ff;
               end
            end
            2'd2: begin
               if (cur_seg[SegWave]) begin
                  rsp_out_byte = {4'd0, rec_wave_ff};
               end else if (cur_seg[SegVol]) begin
                  rsp_out_byte = rec_volb_ff;
               end else begin
                  rsp_out_byte = rec_freq_ff[7:0];
               end
            end
            default: rsp_out_byte = {5'd0, rec_freq_ff[10:8]};
         endcase
      end
   end

   // Assertions.
   `TCDE_ASSERT(a_err_single, clock, reset,
      rsp_valid && rsp_error |-> rsp_last && rsp_out_byte == 8'd0,
      "error result must be a single zero byte")
   `TCDE_ASSERT(a_rec_has_work, clock, reset,
      rec_valid_ff && !rec_err_ff |-> rec_pend_ff != 3'b000,
      "record without error holds no pending command")
   `TCDE_ASSERT(a_idx_in_seg, clock, reset,
      rec_valid_ff && !rec_err_ff && !cur_seg[SegFreq] |-> rec_idx_ff != 2'd3,
      "byte index runs past a three byte command")
   `TCDE_ASSERT(a_wave_known, clock, reset,
      dec_commit && dec_wave_emit |=> wave_known_ff[$past(dec_idx)],
      "waveform sent but not recorded as known")
   `TCDE_ASSERT_ALWAYS(a_stall_full, clock,
      req_stall |-> s1_valid_ff,
      "input stalled while the input register is empty")

endmodule
